FILE: hw/rtl/uri_pv_pkg.sv
// uri_pv_pkg: shared types, constants and helper functions for the URI path
// validator. Used by uri_pv_core and uri_path_validator; depends on nothing.

package uri_pv_pkg;

  // Longest path that is still accepted, in bytes
  localparam int MAX_PATH_LENGTH = 4096;
  // Byte counter saturates at MAX_PATH_LENGTH + 1
  localparam int CNT_W = $clog2(MAX_PATH_LENGTH + 2);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PATH_LENGTH);

  // Byte codes of interest
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  // Reject reason codes
  typedef enum logic [2:0] {
    RSN_NONE   = 3'd0,
    RSN_LONG   = 3'd1,
    RSN_DSLASH = 3'd2,
    RSN_BYTE   = 3'd3,
    RSN_DOT    = 3'd4,
    RSN_COLON  = 3'd5,
    RSN_ESC    = 3'd6
  } reason_t;

  // Percent escape progress
  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  // Per-path scan state
  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic             in_query;
    logic             in_first_seg;
    logic             seg_dots_only;
    logic [1:0]       seg_len_sat;
    esc_phase_t       esc_phase;
    logic [3:0]       esc_high;
    logic             first_slash;
    reason_t          first_err;
  } scan_state_t;

  localparam scan_state_t SCAN_RST = '{
    byte_count:    '0,
    in_query:      1'b0,
    in_first_seg:  1'b1,
    seg_dots_only: 1'b1,
    seg_len_sat:   2'd0,
    esc_phase:     ESC_IDLE,
    esc_high:      4'd0,
    first_slash:   1'b0,
    first_err:     RSN_NONE
  };

  // Hex digit decode: bit 4 set means not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] res;
    res = 5'h10;
    if (b inside {[8'h30:8'h39]}) res = {1'b0, b[3:0]};
    else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) res = {1'b0, b[3:0] + 4'd9};
    return res;
  endfunction

  // Segment is exactly "." or ".."
  function automatic logic is_dot_seg(input scan_state_t s);
    return s.seg_dots_only && (s.seg_len_sat != 2'd0) && (s.seg_len_sat != 2'd3);
  endfunction

endpackage

FILE: hw/rtl/uri_pv_core.sv
// uri_pv_core: combinational per-byte scan step and end-of-path verdict.
// Depends on uri_pv_pkg for the state struct, reason codes and helpers.

module uri_pv_core (
  input  uri_pv_pkg::scan_state_t st,
  input  logic [7:0]              path_byte,
  input  logic                    byte_present,
  input  logic                    is_last,
  output uri_pv_pkg::scan_state_t st_nxt,
  output uri_pv_pkg::reason_t     reason
);

  uri_pv_pkg::scan_state_t s;
  uri_pv_pkg::reason_t     err;
  logic [4:0]              nib;
  logic [7:0]              seg_byte;
  logic                    seg_add;
  logic [uri_pv_pkg::CNT_W-1:0] pos;

  always_comb begin
    s        = st;
    err      = uri_pv_pkg::RSN_NONE;
    nib      = uri_pv_pkg::hex_nibble(path_byte);
    seg_byte = path_byte;
    seg_add  = 1'b0;
    pos      = st.byte_count;

    if (byte_present) begin
      // saturating length count
      if (st.byte_count <= uri_pv_pkg::CNT_LIMIT) begin
        s.byte_count = st.byte_count + 1'b1;
      end

      case (st.esc_phase)
        uri_pv_pkg::ESC_HIGH: begin
          if (nib[4]) begin
            err         = uri_pv_pkg::RSN_ESC;
            s.esc_phase = uri_pv_pkg::ESC_IDLE;
          end else begin
            s.esc_high  = nib[3:0];
            s.esc_phase = uri_pv_pkg::ESC_LOW;
          end
        end
        uri_pv_pkg::ESC_LOW: begin
          s.esc_phase = uri_pv_pkg::ESC_IDLE;
          if (nib[4]) begin
            err = uri_pv_pkg::RSN_ESC;
          end else if (!st.in_query) begin
            // decoded byte only lengthens the segment and feeds dot tracking
            seg_byte = {st.esc_high, nib[3:0]};
            seg_add  = 1'b1;
          end
        end
        default: begin
          if (pos == '0) s.first_slash = (path_byte == uri_pv_pkg::CH_SLASH);
          if (pos == uri_pv_pkg::CNT_W'(1) && st.first_slash &&
              path_byte == uri_pv_pkg::CH_SLASH) begin
            err = uri_pv_pkg::RSN_DSLASH;
          end else if (path_byte <= uri_pv_pkg::CH_SPACE ||
                       path_byte == uri_pv_pkg::CH_DEL ||
                       path_byte == uri_pv_pkg::CH_HASH) begin
            err = uri_pv_pkg::RSN_BYTE;
          end else if (!st.in_query && (path_byte == uri_pv_pkg::CH_SLASH ||
                                        path_byte == uri_pv_pkg::CH_QMARK)) begin
            // segment boundary
            if (uri_pv_pkg::is_dot_seg(st)) err = uri_pv_pkg::RSN_DOT;
            s.in_query      = (path_byte == uri_pv_pkg::CH_QMARK);
            s.in_first_seg  = 1'b0;
            s.seg_len_sat   = 2'd0;
            s.seg_dots_only = 1'b1;
          end else if (!st.in_query && st.in_first_seg &&
                       path_byte == uri_pv_pkg::CH_COLON) begin
            err = uri_pv_pkg::RSN_COLON;
          end else if (path_byte == uri_pv_pkg::CH_PERCENT) begin
            s.esc_phase = uri_pv_pkg::ESC_HIGH;
          end else if (!st.in_query) begin
            seg_add = 1'b1;
          end
        end
      endcase

      // segment length and dot tracking
      if (seg_add) begin
        if (st.seg_len_sat != 2'd3) s.seg_len_sat = st.seg_len_sat + 2'd1;
        if (seg_byte != uri_pv_pkg::CH_DOT) s.seg_dots_only = 1'b0;
      end

      // keep only the first error
      if (err != uri_pv_pkg::RSN_NONE && st.first_err == uri_pv_pkg::RSN_NONE) begin
        s.first_err = err;
      end
    end

    // verdict from the updated state; length error outranks the rest
    if (s.byte_count > uri_pv_pkg::CNT_LIMIT) reason = uri_pv_pkg::RSN_LONG;
    else if (s.first_err != uri_pv_pkg::RSN_NONE) reason = s.first_err;
    else if (s.esc_phase != uri_pv_pkg::ESC_IDLE) reason = uri_pv_pkg::RSN_ESC;
    else if (!s.in_query && uri_pv_pkg::is_dot_seg(s)) reason = uri_pv_pkg::RSN_DOT;
    else reason = uri_pv_pkg::RSN_NONE;

    // start over after a verdict
    st_nxt = is_last ? uri_pv_pkg::SCAN_RST : s;
  end

endmodule

FILE: hw/rtl/uri_path_validator.sv
// uri_path_validator: top level of the request path checker.
// Depends on uri_pv_pkg and uri_pv_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one path byte per transfer,
//   with in_byte_present low for an item that holds no byte (empty path)
//   and in_is_last high on the final item of a path.
//   Result channel (out_valid/out_ready) carries one verdict per path:
//   out_path_ok and out_reject_reason (0 none, 1 too long, 2 double slash,
//   3 bad byte, 4 dot segment, 5 colon, 6 bad escape).
//   Throughput: one item per cycle while no last item waits (below); the scan step is combinational.
//   Each path's verdict passes through the input register, then the result
//   register, before it is shown on the result channel.
//   Items that are not last never wait on the result side. A last item
//   waits in the input register while an earlier verdict is still held;
//   in_ready drops only then.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   scan state to the start of a new path.

module uri_path_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_path_byte,
  input  logic       in_byte_present,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_path_ok,
  output logic [2:0] out_reject_reason
);

  // input register
  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       present_r;
  logic       last_r;

  // scan state and result register
  uri_pv_pkg::scan_state_t st_r;
  uri_pv_pkg::scan_state_t st_nxt;
  uri_pv_pkg::reason_t     reason;
  logic                    out_vld_r;
  uri_pv_pkg::reason_t     reason_r;

  logic advance;
  logic out_free;

  assign out_free = !out_vld_r || out_ready;
  assign advance  = in_vld_r && (!last_r || out_free);
  assign in_ready = !in_vld_r || advance;

  uri_pv_core u_core (
    .st           (st_r),
    .path_byte    (byte_r),
    .byte_present (present_r),
    .is_last      (last_r),
    .st_nxt       (st_nxt),
    .reason       (reason)
  );

  // input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r    <= in_path_byte;
      present_r <= in_byte_present;
      last_r    <= in_is_last;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= uri_pv_pkg::SCAN_RST;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      reason_r <= reason;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_reject_reason = reason_r;
  assign out_path_ok       = (reason_r == uri_pv_pkg::RSN_NONE);

endmodule

FILE: test/tb_uri_path_validator.sv
// tb_uri_path_validator: self-checking testbench for the request path checker.
// Depends on uri_pv_pkg and uri_path_validator. Drives paths byte by byte and
// checks each verdict against a typed-in one or the cycle-free scanner in this file.

module tb_uri_path_validator;
  timeunit 1ns;
  timeprecision 1ps;

  // One input item, plus an optional typed-in verdict
  typedef struct packed {
    logic [7:0]          b;
    logic                present;
    logic                last;
    logic                typed;
    uri_pv_pkg::reason_t want;
  } path_item_t;

  // Scanner state for the path in progress
  typedef struct {
    int unsigned            count;
    bit                     query;
    bit                     first_seg;
    bit                     dots_only;
    bit [1:0]               seg_len;
    uri_pv_pkg::esc_phase_t esc;
    bit [3:0]               esc_hi;
    bit                     lead_slash;
    uri_pv_pkg::reason_t    err;
  } path_scan_t;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  // Directed paths; verdicts typed in only where obvious
  localparam path_item_t DIRECTED [25] = '{
    '{8'hA5,                  1'b0, 1'b1, 1'b1, uri_pv_pkg::RSN_NONE},   // empty path
    '{uri_pv_pkg::CH_SLASH,   1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{uri_pv_pkg::CH_SLASH,   1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_DSLASH}, // leading "//"
    '{8'h00,                  1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_BYTE},   // lowest byte
    '{8'hFF,                  1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_NONE},   // highest byte
    '{uri_pv_pkg::CH_SLASH,   1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{uri_pv_pkg::CH_DOT,     1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_DOT},    // "/." at the end
    '{"a",                    1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{uri_pv_pkg::CH_COLON,   1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_COLON},  // colon, 1st segment
    '{uri_pv_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{"4",                    1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_ESC},    // escape cut short
    '{uri_pv_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{"G",                    1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_ESC},    // non-hex in escape
    '{uri_pv_pkg::CH_DEL,     1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_BYTE},
    '{uri_pv_pkg::CH_PERCENT, 1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},   // "%2e/": escaped dot
    '{"2",                    1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{"e",                    1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{uri_pv_pkg::CH_SLASH,   1'b1, 1'b1, 1'b0, uri_pv_pkg::RSN_NONE},
    '{uri_pv_pkg::CH_QMARK,   1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},   // "?/..": no dot check
    '{uri_pv_pkg::CH_SLASH,   1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{uri_pv_pkg::CH_DOT,     1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{uri_pv_pkg::CH_DOT,     1'b1, 1'b1, 1'b0, uri_pv_pkg::RSN_NONE},
    '{"a",                    1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},
    '{8'h5A,                  1'b0, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE},   // no-byte item
    '{uri_pv_pkg::CH_HASH,    1'b1, 1'b1, 1'b1, uri_pv_pkg::RSN_BYTE}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_path_byte;
  logic       in_byte_present;
  logic       in_is_last;
  logic       out_valid;
  logic       out_ready;
  logic       out_path_ok;
  logic [2:0] out_reject_reason;

  path_item_t          stim_q[$];
  uri_pv_pkg::reason_t pending_verdicts[$];
  path_scan_t          scan;
  bit                  in_took;
  bit                  out_took;
  int                  verdicts_seen;
  int                  mismatches;

  uri_path_validator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_path_byte      (in_path_byte),
    .in_byte_present   (in_byte_present),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_path_ok       (out_path_ok),
    .out_reject_reason (out_reject_reason)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- path scanner ----------------

  function automatic void clear_scan();
    scan.count      = 0;
    scan.query      = 1'b0;
    scan.first_seg  = 1'b1;
    scan.dots_only  = 1'b1;
    scan.seg_len    = 2'd0;
    scan.esc        = uri_pv_pkg::ESC_IDLE;
    scan.esc_hi     = 4'd0;
    scan.lead_slash = 1'b0;
    scan.err        = uri_pv_pkg::RSN_NONE;
  endfunction

  // 0..15 for a hex digit, 16 otherwise
  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return 16;
  endfunction

  function automatic void seg_grow(input logic [7:0] c);
    if (scan.seg_len != 2'd3) scan.seg_len++;
    if (c != uri_pv_pkg::CH_DOT) scan.dots_only = 1'b0;
  endfunction

  // Current segment is "." or ".."
  function automatic bit on_dot_seg();
    return scan.dots_only && (scan.seg_len == 2'd1 || scan.seg_len == 2'd2);
  endfunction

  function automatic void scan_byte(input logic [7:0] c, input int unsigned pos);
    uri_pv_pkg::reason_t hit;
    int                  h;
    hit = uri_pv_pkg::RSN_NONE;
    if (scan.esc == uri_pv_pkg::ESC_HIGH) begin
      h = hex_val(c);
      if (h > 15) begin
        hit = uri_pv_pkg::RSN_ESC;
        scan.esc = uri_pv_pkg::ESC_IDLE;
      end else begin
        scan.esc_hi = h[3:0];
        scan.esc = uri_pv_pkg::ESC_LOW;
      end
    end else if (scan.esc == uri_pv_pkg::ESC_LOW) begin
      h = hex_val(c);
      scan.esc = uri_pv_pkg::ESC_IDLE;
      if (h > 15) hit = uri_pv_pkg::RSN_ESC;
      else if (!scan.query) seg_grow({scan.esc_hi, h[3:0]});  // decoded byte
    end else begin
      if (pos == 0) scan.lead_slash = (c == uri_pv_pkg::CH_SLASH);
      if (pos == 1 && scan.lead_slash && c == uri_pv_pkg::CH_SLASH) begin
        hit = uri_pv_pkg::RSN_DSLASH;
      end else if (c <= uri_pv_pkg::CH_SPACE || c == uri_pv_pkg::CH_DEL ||
                   c == uri_pv_pkg::CH_HASH) begin
        hit = uri_pv_pkg::RSN_BYTE;
      end else if (!scan.query && (c == uri_pv_pkg::CH_SLASH ||
                                   c == uri_pv_pkg::CH_QMARK)) begin
        // segment ends here
        if (on_dot_seg()) hit = uri_pv_pkg::RSN_DOT;
        scan.query     = (c == uri_pv_pkg::CH_QMARK);
        scan.first_seg = 1'b0;
        scan.seg_len   = 2'd0;
        scan.dots_only = 1'b1;
      end else if (!scan.query && scan.first_seg && c == uri_pv_pkg::CH_COLON) begin
        hit = uri_pv_pkg::RSN_COLON;
      end else if (c == uri_pv_pkg::CH_PERCENT) begin
        scan.esc = uri_pv_pkg::ESC_HIGH;
      end else if (!scan.query) begin
        seg_grow(c);
      end
    end
    if (hit != uri_pv_pkg::RSN_NONE && scan.err == uri_pv_pkg::RSN_NONE) scan.err = hit;
  endfunction

  // Returns 1 when the item yields a verdict, with its reason
  function automatic bit predict_item(input logic [7:0] c, input logic present,
                                      input logic last,
                                      output uri_pv_pkg::reason_t rsn);
    int unsigned pos;
    rsn = uri_pv_pkg::RSN_NONE;
    if (present) begin
      pos = scan.count;
      if (scan.count <= uri_pv_pkg::MAX_PATH_LENGTH) scan.count++;
      scan_byte(c, pos);
    end
    if (!last) return 1'b0;
    // length outranks everything
    if (scan.count > uri_pv_pkg::MAX_PATH_LENGTH) rsn = uri_pv_pkg::RSN_LONG;
    else if (scan.err != uri_pv_pkg::RSN_NONE) rsn = scan.err;
    else if (scan.esc != uri_pv_pkg::ESC_IDLE) rsn = uri_pv_pkg::RSN_ESC;
    else if (!scan.query && on_dot_seg()) rsn = uri_pv_pkg::RSN_DOT;
    clear_scan();
    return 1'b1;
  endfunction

  // ---------------- stimulus build ----------------

  function automatic void push_byte(input logic [7:0] c);
    stim_q.push_back('{c, 1'b1, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE});
  endfunction

  function automatic void push_gap();
    stim_q.push_back('{8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, uri_pv_pkg::RSN_NONE});
  endfunction

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return 8'(int'("0") + v);
    return 8'((upper ? int'("A") : int'("a")) + v - 10);
  endfunction

  // Mostly well-formed path with random content; some pure noise
  function automatic void add_random_path();
    int ntok;
    int r;
    int k;
    int first;
    bit noisy;
    first = stim_q.size();
    ntok  = $urandom_range(12);
    noisy = ($urandom_range(99) < 10);
    if (!noisy && $urandom_range(99) < 70) push_byte(uri_pv_pkg::CH_SLASH);
    for (k = 0; k < ntok; k++) begin
      r = $urandom_range(99);
      if (noisy || r >= 86) begin
        push_byte(8'($urandom_range(255)));
      end else if (r < 35) begin
        push_byte(8'(int'("a") + $urandom_range(25)));
      end else if (r < 40) begin
        push_byte(8'(int'("0") + $urandom_range(9)));
      end else if (r < 55) begin
        push_byte(uri_pv_pkg::CH_SLASH);
      end else if (r < 63) begin
        push_byte(uri_pv_pkg::CH_DOT);
      end else if (r < 71) begin
        // well-formed escape, often an encoded dot
        push_byte(uri_pv_pkg::CH_PERCENT);
        if ($urandom_range(99) < 30) begin
          push_byte("2");
          push_byte(hex_char(14, 1'($urandom_range(1))));
        end else begin
          push_byte(hex_char($urandom_range(15), 1'($urandom_range(1))));
          push_byte(hex_char($urandom_range(15), 1'($urandom_range(1))));
        end
      end else if (r < 75) begin
        // broken or truncated escape
        push_byte(uri_pv_pkg::CH_PERCENT);
        if ($urandom_range(1)) push_byte(8'($urandom_range(255)));
      end else if (r < 79) begin
        push_byte(uri_pv_pkg::CH_QMARK);
      end else if (r < 83) begin
        push_byte(uri_pv_pkg::CH_COLON);
      end else begin
        push_gap();
      end
    end
    if (stim_q.size() == first || $urandom_range(99) < 15) push_gap();
    stim_q[stim_q.size()-1].last = 1'b1;
  endfunction

  // ---------------- checking ----------------

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Transfers are sampled at the rising edge; inputs move on the falling one
  always @(posedge clk) begin : path_checker
    uri_pv_pkg::reason_t rsn;
    in_took  = 1'b0;
    out_took = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      in_took = 1'b1;
      if (predict_item(in_path_byte, in_byte_present, in_is_last, rsn)) begin
        if (stim_q.size() != 0 && stim_q[0].typed) rsn = stim_q[0].want;
        pending_verdicts.push_back(rsn);
      end
    end
    if (rst_n && out_valid && out_ready) begin
      out_took = 1'b1;
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("verdict ok=%0b reason=%0d with none pending",
                                out_path_ok, out_reject_reason));
      end else begin
        rsn = pending_verdicts.pop_front();
        if (out_path_ok !== (rsn == uri_pv_pkg::RSN_NONE))
          flag_mismatch($sformatf("verdict %0d: path_ok=%0b, want %0b",
                                  verdicts_seen, out_path_ok,
                                  rsn == uri_pv_pkg::RSN_NONE));
        if (out_reject_reason !== rsn)
          flag_mismatch($sformatf("verdict %0d: reject_reason=%0d, want %0d",
                                  verdicts_seen, out_reject_reason, rsn));
      end
    end
  end

  // ---------------- result side ----------------

  // Random stalls, one long hold-off, and a calm stretch
  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n) begin
        if (!hold_done && verdicts_seen >= 25) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ready <= 1'b0;
        end else if (verdicts_seen >= 70 && verdicts_seen < 100) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= ($urandom_range(99) >= 13);
        end
      end
    end
  end

  // ---------------- watchdog ----------------

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (in_took || out_took) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------- main sequence ----------------

  initial begin : main_seq
    int short_items;
    bit calm;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_path_byte    = 8'h00;
    in_byte_present = 1'b0;
    in_is_last      = 1'b0;
    verdicts_seen   = 0;
    mismatches      = 0;
    clear_scan();

    // directed rows, then random paths
    foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
    short_items = 0;
    while (short_items < 1200) begin
      short_items -= stim_q.size();
      add_random_path();
      short_items += stim_q.size();
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender: decides at a falling edge, and holds each item until it is taken
    while (stim_q.size() != 0) begin
      calm = (verdicts_seen >= 70 && verdicts_seen < 100);
      if (!calm && $urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end else begin
        in_valid        <= 1'b1;
        in_path_byte    <= stim_q[0].b;
        in_byte_present <= stim_q[0].present;
        in_is_last      <= stim_q[0].last;
        @(negedge clk);
        while (!in_took) @(negedge clk);
        void'(stim_q.pop_front());
      end
    end
    in_valid <= 1'b0;

    // wait until every expected verdict has been taken, then idle before the summary
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/uri_pv_pkg.sv
hw/rtl/uri_pv_core.sv
hw/rtl/uri_path_validator.sv
test/tb_uri_path_validator.sv
